@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file cbm_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge while out of reset
`define CBM_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cbm assertion failed");

// property checked on every edge, reset included
`define CBM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cbm assertion failed");

`endif

@@ rtl/core/cbm_pkg.sv @@
// types, codes and decode constants of the cartridge bank mapper
// no dependencies
package cbm_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] IRQ_NONE      = 2'd0;
  localparam logic [1:0] IRQ_PENDING   = 2'd1;
  localparam logic [1:0] IRQ_IMMEDIATE = 2'd2;

  localparam logic CFG_OLD_MODE      = 1'b0;
  localparam logic CFG_IMMEDIATE_IRQ = 1'b1;

  localparam logic [15:0] ADDR_PRG_8000 = 16'h8000;
  localparam logic [15:0] ADDR_PRG_A000 = 16'h8001;
  localparam logic [15:0] ADDR_CHR_01   = 16'h8002;
  localparam logic [15:0] ADDR_CHR_23   = 16'h8003;
  localparam logic [15:0] ADDR_CHR_4    = 16'hA000;
  localparam logic [15:0] ADDR_CHR_5    = 16'hA001;
  localparam logic [15:0] ADDR_CHR_6    = 16'hA002;
  localparam logic [15:0] ADDR_CHR_7    = 16'hA003;
  localparam logic [15:0] ADDR_LINE     = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_EN0  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_EN1  = 16'hC002;
  localparam logic [15:0] ADDR_MIRROR   = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_EN2  = 16'hE001;
  localparam logic [15:0] ADDR_IRQ_EN3  = 16'hE002;

  localparam logic [7:0] OLD_PRG_MASK    = 8'h1F;
  localparam int unsigned MIRROR_BIT     = 6;
  localparam logic [8:0] LAST_VISIBLE    = 9'd239;
  localparam logic [7:0] PRG_A000_RESET  = 8'd1;

  typedef struct packed {
    logic       old_mode;
    logic       immediate_irq;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        render_enabled;
  } item_t;

  typedef struct packed {
    logic [7:0] prg_bank_8000;
    logic [7:0] prg_bank_a000;
    logic [8:0] chr_bank_0;
    logic [8:0] chr_bank_1;
    logic [8:0] chr_bank_2;
    logic [8:0] chr_bank_3;
    logic [7:0] chr_bank_4;
    logic [7:0] chr_bank_5;
    logic [7:0] chr_bank_6;
    logic [7:0] chr_bank_7;
    logic       mirror_horizontal;
    logic [1:0] irq_request;
  } result_t;

endpackage

@@ rtl/core/cbm_chan_if.sv @@
// valid/ready channel interfaces for the mapper's item and result beats
// no dependencies
interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] addr;
  logic [7:0]  data;
  logic [8:0]  scanline;
  logic        render_enabled;

  modport source (output valid, op, addr, data, scanline, render_enabled, input ready);
  modport sink (input valid, op, addr, data, scanline, render_enabled, output ready);
endinterface

interface cbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] prg_bank_8000;
  logic [7:0] prg_bank_a000;
  logic [8:0] chr_bank_0;
  logic [8:0] chr_bank_1;
  logic [8:0] chr_bank_2;
  logic [8:0] chr_bank_3;
  logic [7:0] chr_bank_4;
  logic [7:0] chr_bank_5;
  logic [7:0] chr_bank_6;
  logic [7:0] chr_bank_7;
  logic       mirror_horizontal;
  logic [1:0] irq_request;

  modport source (
    output valid, prg_bank_8000, prg_bank_a000, chr_bank_0, chr_bank_1, chr_bank_2,
           chr_bank_3, chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7,
           mirror_horizontal, irq_request,
    input  ready
  );
  modport sink (
    input  valid, prg_bank_8000, prg_bank_a000, chr_bank_0, chr_bank_1, chr_bank_2,
           chr_bank_3, chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7,
           mirror_horizontal, irq_request,
    output ready
  );
endinterface

@@ rtl/core/cbm_cfg.sv @@
// apb-style configuration registers: old board mode and irq flavour
// depends on cbm_pkg
module cbm_cfg
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;
  logic idx;

  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        CFG_OLD_MODE:      cfg_r.old_mode      <= pwdata[0];
        CFG_IMMEDIATE_IRQ: cfg_r.immediate_irq <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      CFG_OLD_MODE:      prdata[0] = cfg_r.old_mode;
      CFG_IMMEDIATE_IRQ: prdata[0] = cfg_r.immediate_irq;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/cbm_in_stage.sv @@
// input register of the mapper pipeline
// depends on cbm_pkg and cbm_in_if
module cbm_in_stage
  import cbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cbm_in_if.sink    in_ch,
  input  logic      advance,
  output logic      valid,
  output item_t     item
);

  logic  valid_r;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid       = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{op: in_ch.op, addr: in_ch.addr, data: in_ch.data,
                  scanline: in_ch.scanline, render_enabled: in_ch.render_enabled};
    end
  end

endmodule

@@ rtl/core/cbm_core.sv @@
// bank registers, line counter and the decode of one item
// depends on cbm_pkg
module cbm_core
  import cbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [7:0] prg_r [2];
  logic [7:0] prg_nxt [2];
  logic [8:0] chr_lo_r [4];
  logic [8:0] chr_lo_nxt [4];
  logic [7:0] chr_hi_r [4];
  logic [7:0] chr_hi_nxt [4];
  logic       mirror_r, mirror_nxt;
  logic [7:0] line_r, line_nxt;
  logic       armed_r, armed_nxt;
  logic [1:0] req;
  logic [7:0] prg_val;
  logic [8:0] pair_even, pair_odd;

  assign prg_val   = cfg.old_mode ? (item.data & OLD_PRG_MASK) : item.data;
  assign pair_even = {item.data, 1'b0};
  assign pair_odd  = {item.data, 1'b1};

  always_comb begin
    prg_nxt    = prg_r;
    chr_lo_nxt = chr_lo_r;
    chr_hi_nxt = chr_hi_r;
    mirror_nxt = mirror_r;
    line_nxt   = line_r;
    armed_nxt  = armed_r;
    req        = IRQ_NONE;
    if (item.op == OP_WRITE) begin
      case (item.addr)
        ADDR_PRG_8000: begin
          prg_nxt[0] = prg_val;
          if (cfg.old_mode) begin
            mirror_nxt = item.data[MIRROR_BIT];
          end
        end
        ADDR_PRG_A000: prg_nxt[1] = prg_val;
        ADDR_CHR_01: begin
          chr_lo_nxt[0] = pair_even;
          chr_lo_nxt[1] = pair_odd;
        end
        ADDR_CHR_23: begin
          chr_lo_nxt[2] = pair_even;
          chr_lo_nxt[3] = pair_odd;
        end
        ADDR_CHR_4: chr_hi_nxt[0] = item.data;
        ADDR_CHR_5: chr_hi_nxt[1] = item.data;
        ADDR_CHR_6: chr_hi_nxt[2] = item.data;
        ADDR_CHR_7: chr_hi_nxt[3] = item.data;
        ADDR_LINE:  line_nxt = item.data;
        ADDR_IRQ_EN0, ADDR_IRQ_EN1, ADDR_IRQ_EN2, ADDR_IRQ_EN3: begin
          armed_nxt = |item.data;
        end
        ADDR_MIRROR: mirror_nxt = item.data[MIRROR_BIT];
        default: ;
      endcase
    end else if (armed_r && item.render_enabled && item.scanline <= LAST_VISIBLE) begin
      // counter at zero fires and disarms, otherwise it counts the line
      if (line_r == 8'd0) begin
        req       = cfg.immediate_irq ? IRQ_IMMEDIATE : IRQ_PENDING;
        armed_nxt = 1'b0;
      end else begin
        line_nxt = line_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r[0] <= '0;
      prg_r[1] <= PRG_A000_RESET;
      for (int i = 0; i < 4; i++) begin
        chr_lo_r[i] <= '0;
        chr_hi_r[i] <= '0;
      end
      mirror_r <= 1'b0;
      line_r   <= '0;
      armed_r  <= 1'b0;
    end else if (fire) begin
      prg_r    <= prg_nxt;
      chr_lo_r <= chr_lo_nxt;
      chr_hi_r <= chr_hi_nxt;
      mirror_r <= mirror_nxt;
      line_r   <= line_nxt;
      armed_r  <= armed_nxt;
    end
  end

  assign res = '{prg_bank_8000: prg_nxt[0], prg_bank_a000: prg_nxt[1],
                 chr_bank_0: chr_lo_nxt[0], chr_bank_1: chr_lo_nxt[1],
                 chr_bank_2: chr_lo_nxt[2], chr_bank_3: chr_lo_nxt[3],
                 chr_bank_4: chr_hi_nxt[0], chr_bank_5: chr_hi_nxt[1],
                 chr_bank_6: chr_hi_nxt[2], chr_bank_7: chr_hi_nxt[3],
                 mirror_horizontal: mirror_nxt, irq_request: req};

endmodule

@@ rtl/core/cbm_out_stage.sv @@
// result register driving the output channel
// depends on cbm_pkg and cbm_out_if
module cbm_out_stage
  import cbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cbm_out_if.source out_ch,
  input  logic      load,
  input  result_t   res,
  output logic      can_take
);

  logic    valid_r;
  result_t res_r;

  // free when empty or when the waiting beat leaves this cycle
  assign can_take = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      res_r <= res;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.prg_bank_8000     = res_r.prg_bank_8000;
  assign out_ch.prg_bank_a000     = res_r.prg_bank_a000;
  assign out_ch.chr_bank_0        = res_r.chr_bank_0;
  assign out_ch.chr_bank_1        = res_r.chr_bank_1;
  assign out_ch.chr_bank_2        = res_r.chr_bank_2;
  assign out_ch.chr_bank_3        = res_r.chr_bank_3;
  assign out_ch.chr_bank_4        = res_r.chr_bank_4;
  assign out_ch.chr_bank_5        = res_r.chr_bank_5;
  assign out_ch.chr_bank_6        = res_r.chr_bank_6;
  assign out_ch.chr_bank_7        = res_r.chr_bank_7;
  assign out_ch.mirror_horizontal = res_r.mirror_horizontal;
  assign out_ch.irq_request       = res_r.irq_request;

endmodule

@@ rtl/core/cartridge_bank_mapper_with_line_irq.sv @@
// cartridge bank mapper with scanline irq counter: top level
// depends on cbm_pkg, cbm_chan_if, cbm_cfg, cbm_in_stage, cbm_core, cbm_out_stage
//
// in_ch carries one beat per cpu register write (op 0: addr, data) or per
// scanline tick (op 1: scanline, render_enabled). out_ch returns exactly one
// beat per input beat: the full bank map after that item plus the irq code
// it raised (0 none, 1 pending, 2 immediate).
// an input beat is registered, decoded against the bank state and written
// to the result register, which offers it on out_ch.
// while out_ch is ready, one beat per cycle is sustained; the bank
// state advances as each beat moves from the input to the result register.
// when out_ch stalls, the result register holds its beat, the input register
// fills, and in_ch.ready drops until the result beat is taken.
// the apb port sets old_mode (0x0) and immediate_irq (0x4); write it only
// with both channels idle. pready is tied high.
// reset (rst_n low, synchronous) empties both registers and restores the
// power-on bank map: program banks 0 and 1, character banks zero, vertical
// mirroring, line counter zero, irq disarmed, both configuration bits zero.
module cartridge_bank_mapper_with_line_irq
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cbm_in_if.sink      in_ch,
  cbm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    item_valid;
  logic    out_free;
  logic    fire;

  assign fire = item_valid && out_free;

  cbm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbm_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (out_free),
    .valid   (item_valid),
    .item    (item)
  );

  cbm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  cbm_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .load     (item_valid),
    .res      (res),
    .can_take (out_free)
  );

endmodule

@@ rtl/core/cbm_checker.sv @@
// port-level checks of the mapper, bound to the top level
// depends on assert_macros.svh and cartridge_bank_mapper_with_line_irq
`include "assert_macros.svh"

module cbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] chr_bank_0,
  input logic [8:0] chr_bank_2,
  input logic [1:0] irq_request
);

  // reset leaves no result beat behind
  `CBM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a stalled result beat stays put
  `CBM_ASSERT_RST(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(chr_bank_0) && $stable(irq_request)))

  // with the result side free, the pipeline always takes a new beat
  `CBM_ASSERT_RST(a_ready_when_free, clk, rst_n, (!out_valid || out_ready) |-> in_ready)

  // 2k pairs always start on an even 1k bank
  `CBM_ASSERT_RST(a_chr_pair_even, clk, rst_n, out_valid |-> (!chr_bank_0[0] && !chr_bank_2[0]))

endmodule

bind cartridge_bank_mapper_with_line_irq cbm_checker u_cbm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .chr_bank_0  (out_ch.chr_bank_0),
  .chr_bank_2  (out_ch.chr_bank_2),
  .irq_request (out_ch.irq_request)
);

@@ verif/cbm_map_check.sv @@
// result checker for the cartridge bank mapper: watches both channels and the apb port,
// predicts the bank map after every input beat and compares each result beat against it
// depends on cbm_pkg and cbm_chan_if
module cbm_map_check
  import cbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  cbm_in_if                 in_ch,
  cbm_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       outstanding,
  output int unsigned       mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor copy of the mapper state and its two configuration bits
  logic [7:0] prg_bank [2];
  logic [8:0] chr_low [4];
  logic [7:0] chr_high [4];
  logic       mirror_h;
  logic [7:0] line_count;
  logic       irq_on;
  logic       cfg_old;
  logic       cfg_imm;

  result_t    bank_map_q [$];
  result_t    want;
  item_t      beat_in;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
  endtask

  // applies one item to the predicted state and returns the map it leaves behind
  function automatic result_t advance_map(input item_t it);
    result_t    r;
    logic [1:0] req;
    req = IRQ_NONE;
    if (it.op == OP_WRITE) begin
      case (it.addr)
        ADDR_PRG_8000: begin
          if (cfg_old) mirror_h = it.data[MIRROR_BIT];
          prg_bank[0] = cfg_old ? (it.data & OLD_PRG_MASK) : it.data;
        end
        ADDR_PRG_A000: prg_bank[1] = cfg_old ? (it.data & OLD_PRG_MASK) : it.data;
        ADDR_CHR_01: begin
          chr_low[0] = {it.data, 1'b0};
          chr_low[1] = {it.data, 1'b1};
        end
        ADDR_CHR_23: begin
          chr_low[2] = {it.data, 1'b0};
          chr_low[3] = {it.data, 1'b1};
        end
        ADDR_CHR_4, ADDR_CHR_5, ADDR_CHR_6, ADDR_CHR_7: chr_high[it.addr[1:0]] = it.data;
        ADDR_LINE: line_count = it.data;
        ADDR_IRQ_EN0, ADDR_IRQ_EN1, ADDR_IRQ_EN2, ADDR_IRQ_EN3: irq_on = (it.data != 8'd0);
        ADDR_MIRROR: mirror_h = it.data[MIRROR_BIT];
        default: ;
      endcase
    end else if (irq_on && it.render_enabled && it.scanline <= LAST_VISIBLE) begin
      if (line_count == 8'd0) begin
        req = cfg_imm ? IRQ_IMMEDIATE : IRQ_PENDING;
        irq_on = 1'b0;
      end else begin
        line_count = line_count + 8'd1;
      end
    end
    r.prg_bank_8000     = prg_bank[0];
    r.prg_bank_a000     = prg_bank[1];
    r.chr_bank_0        = chr_low[0];
    r.chr_bank_1        = chr_low[1];
    r.chr_bank_2        = chr_low[2];
    r.chr_bank_3        = chr_low[3];
    r.chr_bank_4        = chr_high[0];
    r.chr_bank_5        = chr_high[1];
    r.chr_bank_6        = chr_high[2];
    r.chr_bank_7        = chr_high[3];
    r.mirror_horizontal = mirror_h;
    r.irq_request       = req;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prg_bank[0] = 8'd0;
      prg_bank[1] = PRG_A000_RESET;
      for (int i = 0; i < 4; i++) begin
        chr_low[i]  = 9'd0;
        chr_high[i] = 8'd0;
      end
      mirror_h   = 1'b0;
      line_count = 8'd0;
      irq_on     = 1'b0;
      cfg_old    = 1'b0;
      cfg_imm    = 1'b0;
      mismatches = 0;
      bank_map_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {CFG_OLD_MODE, 2'b00}) cfg_old = pwdata[0];
        else if (paddr == {CFG_IMMEDIATE_IRQ, 2'b00}) cfg_imm = pwdata[0];
      end
      // result beat first: it always belongs to an older item than a beat accepted now
      if (out_ch.valid && out_ch.ready) begin
        if (bank_map_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = bank_map_q.pop_front();
          check_field("prg_bank_8000", 9'(out_ch.prg_bank_8000), 9'(want.prg_bank_8000));
          check_field("prg_bank_a000", 9'(out_ch.prg_bank_a000), 9'(want.prg_bank_a000));
          check_field("chr_bank_0", out_ch.chr_bank_0, want.chr_bank_0);
          check_field("chr_bank_1", out_ch.chr_bank_1, want.chr_bank_1);
          check_field("chr_bank_2", out_ch.chr_bank_2, want.chr_bank_2);
          check_field("chr_bank_3", out_ch.chr_bank_3, want.chr_bank_3);
          check_field("chr_bank_4", 9'(out_ch.chr_bank_4), 9'(want.chr_bank_4));
          check_field("chr_bank_5", 9'(out_ch.chr_bank_5), 9'(want.chr_bank_5));
          check_field("chr_bank_6", 9'(out_ch.chr_bank_6), 9'(want.chr_bank_6));
          check_field("chr_bank_7", 9'(out_ch.chr_bank_7), 9'(want.chr_bank_7));
          check_field("mirror_horizontal", 9'(out_ch.mirror_horizontal),
                      9'(want.mirror_horizontal));
          check_field("irq_request", 9'(out_ch.irq_request), 9'(want.irq_request));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        beat_in.op             = in_ch.op;
        beat_in.addr           = in_ch.addr;
        beat_in.data           = in_ch.data;
        beat_in.scanline       = in_ch.scanline;
        beat_in.render_enabled = in_ch.render_enabled;
        bank_map_q.push_back(advance_map(beat_in));
      end
      outstanding <= bank_map_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// top of the bank mapper testbench: clock, reset, apb configuration, item and result traffic
// depends on cbm_pkg, cbm_chan_if, the mapper rtl and cbm_map_check
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned sent;
  logic        steady_phase;

  cbm_in_if  in_ch ();
  cbm_out_if out_ch ();

  cartridge_bank_mapper_with_line_irq dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cbm_map_check map_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] reg_addr(input int unsigned k);
    case (k)
      0:       return ADDR_PRG_8000;
      1:       return ADDR_PRG_A000;
      2:       return ADDR_CHR_01;
      3:       return ADDR_CHR_23;
      4:       return ADDR_CHR_4;
      5:       return ADDR_CHR_5;
      6:       return ADDR_CHR_6;
      7:       return ADDR_CHR_7;
      8:       return ADDR_MIRROR;
      9:       return ADDR_LINE;
      10:      return ADDR_IRQ_EN0;
      11:      return ADDR_IRQ_EN1;
      12:      return ADDR_IRQ_EN2;
      default: return ADDR_IRQ_EN3;
    endcase
  endfunction

  // valid stays high across back-to-back beats, it only drops for a gap
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = steady_phase ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.addr           <= it.addr;
    in_ch.data           <= it.data;
    in_ch.scanline       <= it.scanline;
    in_ch.render_enabled <= it.render_enabled;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // fields a write ignores are filled with noise
  task automatic write_op(input logic [15:0] a, input logic [7:0] d);
    item_t it;
    it.op             = OP_WRITE;
    it.addr           = a;
    it.data           = d;
    it.scanline       = 9'($urandom_range(0, 511));
    it.render_enabled = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic tick(input logic [8:0] line, input logic render);
    item_t it;
    it.op             = OP_TICK;
    it.addr           = 16'($urandom_range(0, 65535));
    it.data           = 8'($urandom_range(0, 255));
    it.scanline       = line;
    it.render_enabled = render;
    send_item(it);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic old_mode, input logic imm);
    settle();
    write_cfg(CFG_OLD_MODE, old_mode);
    write_cfg(CFG_IMMEDIATE_IRQ, imm);
  endtask

  task automatic random_traffic();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      write_op(reg_addr($urandom_range(0, 13)), 8'($urandom_range(0, 255)));
    end else if (kind == 4) begin
      write_op(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end else if (kind <= 8) begin
      tick(9'(($urandom_range(0, 4) == 0) ? $urandom_range(240, 511) : $urandom_range(0, 239)),
           $urandom_range(0, 5) != 0);
    end else begin
      // load the counter at or just below the wrap so the irq lands within a few lines
      write_op(ADDR_LINE, ($urandom_range(0, 2) == 0) ? 8'h00 : 8'(8'hF8 + $urandom_range(0, 7)));
      write_op(reg_addr($urandom_range(10, 13)),
               ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      n = $urandom_range(2, 10);
      repeat (n) tick(9'($urandom_range(0, 239)), $urandom_range(0, 7) != 0);
    end
  endtask

  // result side: random stalls, plus two long hold-offs so the input side backs up
  initial begin
    int unsigned stall;
    int unsigned beats;
    beats = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (beats == 40 || beats == 260) stall = 120;
      else if (steady_phase) stall = 0;
      else stall = $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      beats++;
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned base;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_WRITE;
    in_ch.addr           = 16'd0;
    in_ch.data           = 8'd0;
    in_ch.scanline       = 9'd0;
    in_ch.render_enabled = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 3'd0;
    pwdata       = 32'd0;
    sent         = 0;
    steady_phase = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(1'b0, 1'b0);
    write_op(ADDR_PRG_8000, 8'hFF);
    write_op(ADDR_PRG_A000, 8'h00);
    write_op(ADDR_CHR_01, 8'hFF);
    write_op(ADDR_CHR_23, 8'h80);
    write_op(ADDR_CHR_4, 8'hFF);
    write_op(ADDR_CHR_5, 8'h00);
    write_op(ADDR_CHR_6, 8'h55);
    write_op(ADDR_CHR_7, 8'hAA);
    write_op(ADDR_MIRROR, 8'h40);
    write_op(ADDR_MIRROR, 8'hBF);
    // unmapped addresses, including a near miss of the decode
    write_op(16'hFFFF, 8'hFF);
    write_op(16'h0000, 8'h00);
    write_op(16'h8004, 8'h12);
    tick(9'd10, 1'b1);
    write_op(ADDR_LINE, 8'hFE);
    write_op(ADDR_IRQ_EN0, 8'h01);
    tick(9'd0, 1'b1);
    tick(LAST_VISIBLE, 1'b1);
    tick(9'd240, 1'b1);
    tick(9'd100, 1'b0);
    tick(9'd511, 1'b1);
    tick(9'd5, 1'b1);
    tick(9'd6, 1'b1);
    write_op(ADDR_IRQ_EN3, 8'h00);
    write_op(ADDR_IRQ_EN1, 8'h80);
    write_op(ADDR_IRQ_EN2, 8'hFF);
    tick(LAST_VISIBLE, 1'b1);

    // old board: 5-bit program banks and mirroring from the 0x8000 write
    set_mode(1'b1, 1'b1);
    write_op(ADDR_PRG_8000, 8'hFF);
    write_op(ADDR_PRG_8000, 8'h3F);
    write_op(ADDR_PRG_A000, 8'hE0);
    write_op(ADDR_IRQ_EN0, 8'h01);
    tick(9'd0, 1'b1);

    base = sent;
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph[0], ph[1]);
      steady_phase = ($urandom_range(0, 3) == 0);
      while (sent < base + (ph + 1) * 50) random_traffic();
    end
    steady_phase = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
